// ===== rtl/sstb_pkg.sv =====
// Shared constants, types and search functions for the sector skew table builder.
package sstb_pkg;

   localparam int MAX_SECTORS = 64;
   localparam int SLOT_W      = $clog2(MAX_SECTORS);
   localparam int CNT_W       = SLOT_W + 1;
   localparam int SKEW_W      = 8;

   localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_SECTORS);

   typedef logic [MAX_SECTORS-1:0] map_type;

   typedef struct packed {
      logic start;
      logic reduce_step;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic count_zero;
      logic reduce_done;
      logic last_entry;
      logic out_ready;
   } status_type;

   function automatic logic [SLOT_W-1:0] lowest_set(input map_type v);
      logic [SLOT_W-1:0] idx;
      idx = '0;
      for (int i = MAX_SECTORS - 1; i >= 0; i--) begin
         if (v[i]) idx = SLOT_W'(i);
      end
      return idx;
   endfunction

   function automatic logic [SLOT_W-1:0] highest_set(input map_type v);
      logic [SLOT_W-1:0] idx;
      idx = '0;
      for (int i = 0; i < MAX_SECTORS; i++) begin
         if (v[i]) idx = SLOT_W'(i);
      end
      return idx;
   endfunction

endpackage

// ===== rtl/sstb_ctrl.sv =====
// Controller state machine: request intake, step reduction and table emission.
module sstb_ctrl import sstb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_REDUCE = 2'd1;
   localparam logic [1:0] ST_EMIT   = 2'd2;

   logic [1:0] state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      cmd         = '0;
      cmd.start   = (state_ff == ST_IDLE) && req_valid;
      cmd.reduce_step = (state_ff == ST_REDUCE) && !status.reduce_done;
      cmd.emit    = (state_ff == ST_EMIT) && status.out_ready;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_REDUCE;
         end
         ST_REDUCE: begin
            if (status.count_zero) state_in = ST_IDLE;
            else if (status.reduce_done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_ready && status.last_entry) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/sstb_dp.sv =====
// Datapath: occupancy map, candidate stepping, free slot search and result register.
module sstb_dp import sstb_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic signed [SKEW_W-1:0] req_skew,
   input  logic [CNT_W-1:0]         req_sector_count,
   input  cmd_type                  cmd,
   output status_type               status,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [SLOT_W-1:0]        rsp_logical_index,
   output logic [SLOT_W-1:0]        rsp_slot,
   output logic                     rsp_last
);

   logic [CNT_W-1:0]  count_ff, count_in;
   logic              backward_ff, backward_in;
   logic [SKEW_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]  index_ff, index_in;
   logic [SLOT_W-1:0] cand_ff, cand_in;
   map_type           occ_ff, occ_in;
   logic              out_valid_ff, out_valid_in;
   logic [SLOT_W-1:0] out_index_ff, out_index_in;
   logic [SLOT_W-1:0] out_slot_ff, out_slot_in;
   logic              out_last_ff, out_last_in;

   logic [SKEW_W-1:0] skew_mag;
   logic [CNT_W-1:0]  sat_count;
   logic [SKEW_W-1:0] count_ext;
   logic [CNT_W:0]    cand_sum;
   logic [CNT_W:0]    count_wide;
   map_type           free_map, fwd_map, bwd_map;
   logic [SLOT_W-1:0] found;
   logic              last_entry;

   assign skew_mag  = req_skew[SKEW_W-1] ? SKEW_W'(-req_skew) : SKEW_W'(req_skew);
   assign sat_count = (req_sector_count > MAX_COUNT) ? MAX_COUNT : req_sector_count;
   assign count_ext = SKEW_W'(count_ff);
   assign count_wide = (CNT_W+1)'(count_ff);
   assign last_entry = (index_ff == count_ff - CNT_W'(1));

   always_comb begin
      for (int i = 0; i < MAX_SECTORS; i++) begin
         free_map[i] = !occ_ff[i] && (CNT_W'(i) < count_ff);
         fwd_map[i]  = free_map[i] && (SLOT_W'(i) >= cand_ff);
         bwd_map[i]  = free_map[i] && (SLOT_W'(i) <= cand_ff);
      end
   end

   always_comb begin
      if (backward_ff) begin
         found = (bwd_map != '0) ? highest_set(bwd_map) : highest_set(free_map);
      end else begin
         found = (fwd_map != '0) ? lowest_set(fwd_map) : lowest_set(free_map);
      end
   end

   assign cand_sum = (CNT_W+1)'(cand_ff) + (CNT_W+1)'(step_ff);

   always_comb begin
      count_in     = count_ff;
      backward_in  = backward_ff;
      step_in      = step_ff;
      index_in     = index_ff;
      cand_in      = cand_ff;
      occ_in       = occ_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_index_in = out_index_ff;
      out_slot_in  = out_slot_ff;
      out_last_in  = out_last_ff;
      if (cmd.start) begin
         count_in    = sat_count;
         backward_in = req_skew[SKEW_W-1];
         step_in     = skew_mag;
         index_in    = '0;
         cand_in     = '0;
         occ_in      = '0;
      end
      if (cmd.reduce_step) begin
         step_in = step_ff - count_ext;
      end
      if (cmd.emit) begin
         occ_in[found] = 1'b1;
         index_in      = index_ff + CNT_W'(1);
         cand_in       = (cand_sum >= count_wide) ? SLOT_W'(cand_sum - count_wide)
                                                  : SLOT_W'(cand_sum);
         out_valid_in  = 1'b1;
         out_index_in  = index_ff[SLOT_W-1:0];
         out_slot_in   = found;
         out_last_in   = last_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         index_ff     <= '0;
         occ_ff       <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         index_ff     <= index_in;
         occ_ff       <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff     <= count_in;
      backward_ff  <= backward_in;
      step_ff      <= step_in;
      cand_ff      <= cand_in;
      out_index_ff <= out_index_in;
      out_slot_ff  <= out_slot_in;
      out_last_ff  <= out_last_in;
   end

   assign status.count_zero  = (count_ff == '0);
   assign status.reduce_done = (step_ff < count_ext);
   assign status.last_entry  = last_entry;
   assign status.out_ready   = !out_valid_ff || !rsp_stall;

   assign rsp_valid         = out_valid_ff;
   assign rsp_logical_index = out_index_ff;
   assign rsp_slot          = out_slot_ff;
   assign rsp_last          = out_last_ff;

endmodule

// ===== rtl/sector_skew_table_builder_unit.sv =====
// Top level of the sector skew table builder: controller plus datapath.
//
//   channel | direction | transfer when         | fields
//   req     | in        | req_valid & !req_stall | skew, sector_count
//   rsp     | out       | rsp_valid & !rsp_stall | logical_index, slot, last
//
// A request is taken only when the controller is idle. After intake the step
// magnitude is reduced modulo the count, one subtraction a cycle, then one entry
// per cycle is produced while rsp_stall is low, each using a combinational
// find-first-free over the 64-bit map.
// Reset is synchronous and empties the result register; rsp_stall holds the
// result register and pauses the emission.
module sector_skew_table_builder_unit import sstb_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [SKEW_W-1:0] req_skew,
   input  logic [CNT_W-1:0]         req_sector_count,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [SLOT_W-1:0]        rsp_logical_index,
   output logic [SLOT_W-1:0]        rsp_slot,
   output logic                     rsp_last
);

   cmd_type    cmd;
   status_type status;

   sstb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sstb_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_skew          (req_skew),
      .req_sector_count  (req_sector_count),
      .cmd               (cmd),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_logical_index (rsp_logical_index),
      .rsp_slot          (rsp_slot),
      .rsp_last          (rsp_last)
   );

endmodule

// ===== rtl/sstb_chk.sv =====
// Port-level checker for the sector skew table builder, bound to the top level.
module sstb_chk import sstb_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic signed [SKEW_W-1:0] req_skew,
   input logic [CNT_W-1:0]         req_sector_count,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic [SLOT_W-1:0]        rsp_logical_index,
   input logic [SLOT_W-1:0]        rsp_slot,
   input logic                     rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_slot)
         && $stable(rsp_logical_index) && $stable(rsp_last))
      else $error("stalled result changed");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_skew)
         && $stable(req_sector_count))
      else $error("stalled request changed");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request transfer not followed by busy");

   a_first_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_logical_index == '0 |-> rsp_slot == '0)
      else $error("first entry not in slot zero");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("reset did not clear the block");

endmodule

bind sector_skew_table_builder_unit sstb_chk u_sstb_chk (.*);
